[hw/rtl/pqms_pkg.sv]
package pqms_pkg;

  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int unsigned AddrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OccW  = 8;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] served_value;
    logic signed [31:0] served_priority;
    logic [OccW-1:0]    occupancy;
  } rsp_t;

  // one stored pair as held in the entry memory
  typedef struct packed {
    logic signed [31:0] pri;
    logic signed [31:0] val;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

[hw/rtl/pqms_ram.sv]
module pqms_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 128
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/pqms_best.sv]
module pqms_best (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       first_i,
  input  logic [pqms_pkg::AddrW-1:0] idx_i,
  input  pqms_pkg::entry_t           ent_i,
  output pqms_pkg::entry_t           best_o,
  output logic [pqms_pkg::AddrW-1:0] best_idx_o
);

  pqms_pkg::entry_t           best_q;
  logic [pqms_pkg::AddrW-1:0] idx_q;
  logic                       take;

  // higher priority wins, then larger value; equal pairs keep the earlier one
  assign take = first_i || (ent_i.pri > best_q.pri) ||
                ((ent_i.pri == best_q.pri) && (ent_i.val > best_q.val));

  assign best_o     = take ? ent_i : best_q;
  assign best_idx_o = take ? idx_i : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      idx_q  <= '0;
    end else if (valid_i) begin
      best_q <= best_o;
      idx_q  <= best_idx_o;
    end
  end

endmodule

[hw/rtl/priority_queue_max_select.sv]
// channel   | ports                 | handshake
// ----------+-----------------------+-----------------------------------------
// request   | start, busy, req_i    | word taken at an edge with start & !busy
// result    | strobe, rsp_o         | word valid for one cycle, taken at its end
//
// an enqueue or a refused request gives its result in the cycle after it is
// taken and leaves busy low, so one can be issued every cycle.
// a dequeue reads every held entry once through the entry memory read port,
// one per cycle, and busy stays high while it scans; its result is strobed
// from a register once the last entry has been read. the hole left by the
// served entry is filled by the last entry in the final scan cycle.
// asynchronous active-low reset empties the queue; memory contents are kept.
// the receiver cannot stall: every result word is taken in its strobe cycle.
module priority_queue_max_select (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  pqms_pkg::req_t  req_i,
  output logic            strobe,
  output pqms_pkg::rsp_t  rsp_o
);

  typedef enum logic {
    IDLE,
    SCAN
  } state_e;

  state_e                     state_q, state_d;
  logic [pqms_pkg::CntW-1:0]  count_q, count_d;
  logic [pqms_pkg::AddrW-1:0] didx_q, didx_d;
  logic                       strobe_q, strobe_d;
  pqms_pkg::rsp_t             rsp_q, rsp_d;

  logic                       accept;
  logic                       last;
  logic [pqms_pkg::CntW-1:0]  next_idx;
  logic                       we, re;
  logic [pqms_pkg::AddrW-1:0] waddr, raddr;
  pqms_pkg::entry_t           wdata, rdata, best;
  logic [pqms_pkg::AddrW-1:0] best_idx;

  assign busy     = (state_q != IDLE);
  assign accept   = start && !busy;
  assign next_idx = pqms_pkg::CntW'(didx_q) + pqms_pkg::CntW'(1);
  assign last     = (state_q == SCAN) &&
                    (pqms_pkg::CntW'(didx_q) == count_q - pqms_pkg::CntW'(1));

  pqms_ram #(
    .Width (pqms_pkg::EntryW),
    .Depth (pqms_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pqms_best u_best (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (state_q == SCAN),
    .first_i    (didx_q == '0),
    .idx_i      (didx_q),
    .ent_i      (rdata),
    .best_o     (best),
    .best_idx_o (best_idx)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    didx_d   = didx_q;
    strobe_d = 1'b0;
    rsp_d    = rsp_q;
    we       = 1'b0;
    waddr    = pqms_pkg::AddrW'(count_q);
    wdata    = '{pri: req_i.item_priority, val: req_i.item_value};
    re       = 1'b0;
    raddr    = '0;

    case (state_q)
      IDLE: begin
        if (accept) begin
          rsp_d.served_value    = '0;
          rsp_d.served_priority = '0;
          rsp_d.status          = pqms_pkg::ST_DONE;
          if (req_i.req_type == pqms_pkg::REQ_ENQ) begin
            strobe_d = 1'b1;
            if (count_q == pqms_pkg::CntW'(pqms_pkg::QUEUE_DEPTH)) begin
              rsp_d.status = pqms_pkg::ST_FULL;
            end else begin
              we      = 1'b1;
              count_d = count_q + pqms_pkg::CntW'(1);
            end
            rsp_d.occupancy = pqms_pkg::OccW'(count_d);
          end else if (count_q == '0) begin
            strobe_d        = 1'b1;
            rsp_d.status    = pqms_pkg::ST_EMPTY;
            rsp_d.occupancy = '0;
          end else begin
            re      = 1'b1;
            didx_d  = '0;
            state_d = SCAN;
          end
        end
      end
      SCAN: begin
        // data for entry didx_q is on the read port this cycle
        if (next_idx < count_q) begin
          re    = 1'b1;
          raddr = pqms_pkg::AddrW'(next_idx);
        end
        didx_d = pqms_pkg::AddrW'(next_idx);
        if (last) begin
          // the last entry moves into the served slot
          we                    = 1'b1;
          waddr                 = best_idx;
          wdata                 = rdata;
          count_d               = count_q - pqms_pkg::CntW'(1);
          strobe_d              = 1'b1;
          rsp_d.status          = pqms_pkg::ST_DONE;
          rsp_d.served_value    = best.val;
          rsp_d.served_priority = best.pri;
          rsp_d.occupancy       = pqms_pkg::OccW'(count_d);
          state_d               = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= IDLE;
      count_q  <= '0;
      didx_q   <= '0;
      strobe_q <= 1'b0;
      rsp_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      didx_q   <= didx_d;
      strobe_q <= strobe_d;
      rsp_q    <= rsp_d;
    end
  end

  assign strobe = strobe_q;
  assign rsp_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pqms_pkg::CntW'(pqms_pkg::QUEUE_DEPTH))
    else $error("entry count beyond depth");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && (rsp_o.status == pqms_pkg::ST_EMPTY) |-> (count_q == '0))
    else $error("empty word while entries held");

  a_deq_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.req_type == pqms_pkg::REQ_DEQ) && (count_q != '0)
    |=> (state_q == SCAN) && (didx_q == '0))
    else $error("dequeue did not start a scan");

  a_scan_drops_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last |=> strobe && (count_q == $past(count_q) - pqms_pkg::CntW'(1)))
    else $error("served dequeue did not remove one entry");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SCAN) |-> (pqms_pkg::CntW'(didx_q) < count_q))
    else $error("scan index past occupancy");

endmodule
